// ===== design/fnuv_pkg.sv =====
// fnuv_pkg: shared types and constants for the face normal / uv vertex emitter
// no dependencies

package fnuv_pkg;

  typedef enum logic [3:0] {
    ST_CAPTURE,
    ST_DIFF,
    ST_CROSS,
    ST_NORMALIZE,
    ST_EMIT_VTX,
    ST_EMIT_IDX
  } fsm_t;

  localparam logic REC_VERTEX = 1'b0;
  localparam logic REC_INDEX  = 1'b1;
  localparam int   MAG_BITS   = 30;
  localparam int   IDX_BITS   = 31;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } unit_ctl_t;

endpackage

// ===== design/fnuv_isqrt.sv =====
// fnuv_isqrt: bit-serial integer square root, one result bit per cycle
// depends on fnuv_pkg (unit_ctl_t)

module fnuv_isqrt #(
  parameter int IN_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [IN_BITS-1:0]      radicand,
  output fnuv_pkg::unit_ctl_t     ctl,
  output logic [IN_BITS/2-1:0]    root
);

  localparam int RB = IN_BITS / 2;
  localparam int CB = $clog2(RB + 1);

  logic [IN_BITS-1:0] rem;
  logic [IN_BITS-1:0] rad;
  logic [CB-1:0]      cnt;
  logic               busy;
  logic               done;
  logic [IN_BITS+1:0] trial;
  logic [IN_BITS+1:0] rem_sh;

  // restoring digit step: bring down two bits, try 4r+1
  always_comb begin
    rem_sh = {rem, rad[IN_BITS-1 -: 2]};
    trial  = {{(IN_BITS - RB){1'b0}}, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CB'(RB);
        rem  <= '0;
        rad  <= radicand;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[IN_BITS-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= IN_BITS'(rem_sh - trial);
          root <= {root[RB-2:0], 1'b1};
        end else begin
          rem  <= IN_BITS'(rem_sh);
          root <= {root[RB-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CB'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign ctl.done  = done;

endmodule

// ===== design/fnuv_divider.sv =====
// fnuv_divider: shared restoring divider, one quotient bit per cycle
// depends on fnuv_pkg (unit_ctl_t)

module fnuv_divider #(
  parameter int N_BITS = 48,
  parameter int D_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [N_BITS-1:0]    numer,
  input  logic [D_BITS-1:0]    denom,
  output fnuv_pkg::unit_ctl_t  ctl,
  output logic [N_BITS-1:0]    quot
);

  localparam int CB = $clog2(N_BITS + 1);

  logic [D_BITS:0]     rem;
  logic [D_BITS-1:0]   den;
  logic [CB-1:0]       cnt;
  logic                busy;
  logic                done;
  logic [D_BITS+1:0]   rem_sh;

  assign rem_sh = {rem, quot[N_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CB'(N_BITS);
        rem  <= '0;
        den  <= denom;
        quot <= numer;
      end else if (busy) begin
        // quotient bits shift in where numerator bits leave
        if (rem_sh >= {2'b00, den}) begin
          rem  <= (D_BITS+1)'(rem_sh - {2'b00, den});
          quot <= {quot[N_BITS-2:0], 1'b1};
        end else begin
          rem  <= (D_BITS+1)'(rem_sh);
          quot <= {quot[N_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CB'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign ctl.done  = done;

endmodule

// ===== design/face_normal_uv_vertex_emitter_unit.sv =====
// face_normal_uv_vertex_emitter_unit: top level, vertex capture, sequencer and output
// depends on fnuv_pkg, fnuv_isqrt, fnuv_divider

// Vertices are taken one item at a time; the first vertex of a primitive picks
// triangle (func 0) or quad (func 1). A vertex that does not complete a
// primitive is taken without a stall. On the completing vertex the block stops
// taking items and works the face normal through one shared multiplier (cross
// product terms, a common magnitude shift of one bit per cycle, then the
// three squares), one bit-serial square root and one shared divider (3 divides).
// It then emits 3 or 4 vertex records and 3 or 6 index records while the
// output is not stalled; the two uv products of each vertex record are formed
// on the same multiplier before it is offered. The serial divider sets most of
// the cost of a face.

module face_normal_uv_vertex_emitter_unit #(
  parameter int COORD_BITS  = 32,
  parameter int NORMAL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [31:0]                   cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic signed [COORD_BITS-1:0]  x_coord,
  input  logic signed [COORD_BITS-1:0]  y_coord,
  input  logic signed [COORD_BITS-1:0]  z_coord,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          record_kind,
  output logic signed [COORD_BITS-1:0]  pos_x,
  output logic signed [COORD_BITS-1:0]  pos_y,
  output logic signed [COORD_BITS-1:0]  pos_z,
  output logic signed [NORMAL_BITS-1:0] norm_x,
  output logic signed [NORMAL_BITS-1:0] norm_y,
  output logic signed [NORMAL_BITS-1:0] norm_z,
  output logic signed [COORD_BITS-1:0]  tex_u,
  output logic signed [COORD_BITS-1:0]  tex_v,
  output logic [30:0]                   vertex_index,
  output logic                          last_of_run
);

  localparam int DB   = COORD_BITS + 1;        // difference width
  localparam int PB   = 2 * DB;                // product width
  localparam int CRB  = PB + 1;                // cross component width
  localparam int MB   = fnuv_pkg::MAG_BITS;
  localparam int SB   = 2 * MB + 2;            // sum of squares width
  localparam int RB   = SB / 2;
  localparam int FB   = NORMAL_BITS - 2;
  localparam int NB   = MB + FB + 1;           // divider numerator width
  localparam int MW   = (DB > 33) ? DB : 33;   // multiplier operand width
  localparam int TB   = MW + 33;               // uv product width

  // vertex store
  logic signed [COORD_BITS-1:0] vx [4];
  logic signed [COORD_BITS-1:0] vy [4];
  logic signed [COORD_BITS-1:0] vz [4];
  logic [2:0]  captured_count;
  logic        primitive_is_quad;
  logic [30:0] next_vertex_number;
  logic [31:0] uv_reciprocal;

  fnuv_pkg::fsm_t state, state_next;

  logic [3:0]  step;           // micro step inside a state
  logic [3:0]  rec;            // record counter
  logic signed [DB-1:0] a [3];
  logic signed [DB-1:0] b [3];
  logic signed [CRB-1:0] cr [3];
  logic [CRB-1:0] mag [3];
  logic [2:0]  neg;
  logic [SB-1:0] s2;
  logic [NORMAL_BITS-1:0] nrm [3];
  logic [1:0]  comp;

  // shared multiplier
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [2*MW-1:0] mul_p;
  logic signed [2*MW-1:0] prod_q;
  assign mul_p = mul_a * mul_b;

  logic accept_in;
  logic out_take;
  logic [2:0] nverts;
  logic [2:0] nidx_m1;
  logic       completes;

  assign accept_in = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = (state != fnuv_pkg::ST_CAPTURE);

  // kind of the primitive in flight
  logic cur_quad;
  assign cur_quad  = (captured_count == 3'd0) ? func : primitive_is_quad;
  assign completes = (captured_count == (cur_quad ? 3'd3 : 3'd2));
  assign nverts    = primitive_is_quad ? 3'd4 : 3'd3;
  assign nidx_m1   = primitive_is_quad ? 3'd5 : 3'd2;

  // square root and divider units
  fnuv_pkg::unit_ctl_t sq_ctl, dv_ctl;
  logic [RB-1:0] sq_root;
  logic [NB-1:0] dv_quot;
  logic sq_start, dv_start;
  logic [RB-1:0] len;
  logic [NB-1:0] dv_num;

  fnuv_isqrt #(.IN_BITS(SB)) u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(s2),
    .ctl(sq_ctl), .root(sq_root)
  );

  fnuv_divider #(.N_BITS(NB), .D_BITS(RB)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .numer(dv_num), .denom(len),
    .ctl(dv_ctl), .quot(dv_quot)
  );

  // magnitude of the component in turn, shifted into the normal range
  logic [MB-1:0] mv [3];
  logic [CRB-1:0] all_or;
  assign all_or = mag[0] | mag[1] | mag[2];
  always_comb begin
    for (int i = 0; i < 3; i++) mv[i] = mag[i][MB-1:0];
  end
  assign dv_num = {1'b0, mv[comp], {FB{1'b0}}} + NB'(len >> 1);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) uv_reciprocal <= 32'd65536;
    else if (cfg_we) uv_reciprocal <= cfg_data;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fnuv_pkg::ST_CAPTURE:   if (accept_in && completes) state_next = fnuv_pkg::ST_DIFF;
      fnuv_pkg::ST_DIFF:      state_next = fnuv_pkg::ST_CROSS;
      fnuv_pkg::ST_CROSS:     if (step == 4'd7) state_next = fnuv_pkg::ST_NORMALIZE;
      fnuv_pkg::ST_NORMALIZE: if (step == 4'd9) state_next = fnuv_pkg::ST_EMIT_VTX;
      fnuv_pkg::ST_EMIT_VTX:
        if (out_take && rec == {1'b0, nverts - 3'd1}) state_next = fnuv_pkg::ST_EMIT_IDX;
      fnuv_pkg::ST_EMIT_IDX:
        if (out_take && rec == {1'b0, nidx_m1}) state_next = fnuv_pkg::ST_CAPTURE;
      default:                state_next = fnuv_pkg::ST_CAPTURE;
    endcase
  end

  // unit starts
  always_comb begin
    sq_start = (state == fnuv_pkg::ST_NORMALIZE) && (step == 4'd1);
    dv_start = (state == fnuv_pkg::ST_NORMALIZE) && (step == 4'd3) && !dv_ctl.busy
               && !dv_ctl.done && (len != '0);
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      fnuv_pkg::ST_CROSS: begin
        case (step[2:0])
          3'd0: begin mul_a = MW'(a[1]); mul_b = MW'(b[2]); end
          3'd1: begin mul_a = MW'(a[2]); mul_b = MW'(b[1]); end
          3'd2: begin mul_a = MW'(a[2]); mul_b = MW'(b[0]); end
          3'd3: begin mul_a = MW'(a[0]); mul_b = MW'(b[2]); end
          3'd4: begin mul_a = MW'(a[0]); mul_b = MW'(b[1]); end
          3'd5: begin mul_a = MW'(a[1]); mul_b = MW'(b[0]); end
          default: ;
        endcase
      end
      fnuv_pkg::ST_NORMALIZE: begin
        // squares on steps 5, 6, 7 for components 0, 1, 2
        if (step == 4'd5) mul_a = MW'($signed({1'b0, mv[0]}));
        else if (step == 4'd6) mul_a = MW'($signed({1'b0, mv[1]}));
        else mul_a = MW'($signed({1'b0, mv[2]}));
        mul_b = mul_a;
      end
      fnuv_pkg::ST_EMIT_VTX: begin
        mul_a = (step[0] == 1'b0) ? MW'(vx[rec[1:0]]) : MW'(vy[rec[1:0]]);
        mul_b = MW'($signed({1'b0, uv_reciprocal}));
      end
      default: ;
    endcase
  end

  // uv rounding and saturation of the product in prod_q
  function automatic logic [COORD_BITS-1:0] sat_uv(input logic signed [2*MW-1:0] p);
    logic signed [2*MW-1:0] q;
    logic signed [2*MW-1:0] hi, lo;
    begin
      q  = (p + (2*MW)'(32768)) >>> 16;
      hi = (2*MW)'((65'sd1 <<< (COORD_BITS - 1)) - 65'sd1);
      lo = -hi - (2*MW)'(1);
      if (q > hi) sat_uv = hi[COORD_BITS-1:0];
      else if (q < lo) sat_uv = lo[COORD_BITS-1:0];
      else sat_uv = q[COORD_BITS-1:0];
    end
  endfunction

  logic [COORD_BITS-1:0] u_hold;
  logic [COORD_BITS-1:0] uv_u, uv_v;
  logic                  vtx_ready;

  // datapath sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= fnuv_pkg::ST_CAPTURE;
      captured_count     <= 3'd0;
      primitive_is_quad  <= 1'b0;
      next_vertex_number <= '0;
      step               <= '0;
      rec                <= '0;
      out_valid          <= 1'b0;
      vtx_ready          <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        fnuv_pkg::ST_CAPTURE: begin
          if (accept_in) begin
            vx[captured_count[1:0]] <= x_coord;
            vy[captured_count[1:0]] <= y_coord;
            vz[captured_count[1:0]] <= z_coord;
            if (captured_count == 3'd0) primitive_is_quad <= func;
            captured_count <= completes ? 3'd0 : captured_count + 3'd1;
          end
          step <= '0;
        end
        fnuv_pkg::ST_DIFF: begin
          a[0] <= DB'(vx[2]) - DB'(vx[0]);
          a[1] <= DB'(vy[2]) - DB'(vy[0]);
          a[2] <= DB'(vz[2]) - DB'(vz[0]);
          b[0] <= DB'(vx[1]) - DB'(vx[0]);
          b[1] <= DB'(vy[1]) - DB'(vy[0]);
          b[2] <= DB'(vz[1]) - DB'(vz[0]);
          step <= '0;
        end
        fnuv_pkg::ST_CROSS: begin
          // products in pairs, subtract on the second of each pair
          step <= (step == 4'd7) ? 4'd0 : step + 4'd1;
          prod_q <= mul_p;
          if (step == 4'd1) cr[0] <= CRB'($signed(prod_q[PB-1:0])) - CRB'($signed(mul_p[PB-1:0]));
          if (step == 4'd3) cr[1] <= CRB'($signed(prod_q[PB-1:0])) - CRB'($signed(mul_p[PB-1:0]));
          if (step == 4'd5) cr[2] <= CRB'($signed(prod_q[PB-1:0])) - CRB'($signed(mul_p[PB-1:0]));
          if (step == 4'd6) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= cr[i][CRB-1];
              mag[i] <= cr[i][CRB-1] ? CRB'(-cr[i]) : CRB'(cr[i]);
            end
          end
        end
        fnuv_pkg::ST_NORMALIZE: begin
          case (step)
            4'd0: begin
              // common right shift, one bit per cycle, until below 2^30
              if (all_or[CRB-1:MB] != '0) begin
                for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
              end else begin
                step <= 4'd5;
                s2   <= '0;
              end
            end
            4'd5, 4'd6, 4'd7: begin
              s2   <= s2 + SB'(unsigned'(mul_p[2*MB-1:0]));
              step <= step + 4'd1;
            end
            4'd8: step <= 4'd1;
            4'd1: step <= 4'd2;
            4'd2: begin
              if (sq_ctl.done) begin
                len  <= sq_root;
                comp <= 2'd0;
                step <= 4'd3;
              end
            end
            4'd3: begin
              if (len == '0) begin
                for (int i = 0; i < 3; i++) nrm[i] <= '0;
                step <= 4'd9;
              end else if (dv_ctl.done) begin
                nrm[comp] <= neg[comp] ? NORMAL_BITS'(-dv_quot) : NORMAL_BITS'(dv_quot);
                if (comp == 2'd2) step <= 4'd9;
                else comp <= comp + 2'd1;
              end
            end
            default: begin
              step <= '0;
              rec  <= '0;
            end
          endcase
        end
        fnuv_pkg::ST_EMIT_VTX: begin
          if (out_take) begin
            out_valid <= 1'b0;
            vtx_ready <= 1'b0;
            step      <= '0;
            if (rec == {1'b0, nverts - 3'd1}) rec <= '0;
            else rec <= rec + 4'd1;
          end else if (!vtx_ready) begin
            step <= step + 4'd1;
            if (step == 4'd0) u_hold <= '0;
            if (step == 4'd1) u_hold <= sat_uv(prod_q);
            prod_q <= mul_p;
            if (step == 4'd2) begin
              uv_u      <= u_hold;
              uv_v      <= sat_uv(prod_q);
              vtx_ready <= 1'b1;
              out_valid <= 1'b1;
            end
          end
        end
        fnuv_pkg::ST_EMIT_IDX: begin
          if (!out_valid || out_take) begin
            if (out_take && rec == {1'b0, nidx_m1}) begin
              out_valid          <= 1'b0;
              rec                <= '0;
              next_vertex_number <= next_vertex_number + 31'(nverts);
            end else begin
              out_valid <= 1'b1;
              if (out_take) rec <= rec + 4'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // index offset for the record in flight
  logic [2:0] idx_off;
  always_comb begin
    case (rec[2:0])
      3'd0: idx_off = 3'd0;
      3'd1: idx_off = 3'd1;
      3'd2: idx_off = 3'd2;
      3'd3: idx_off = 3'd0;
      3'd4: idx_off = 3'd2;
      3'd5: idx_off = 3'd3;
      default: idx_off = 3'd0;
    endcase
  end

  // output fields
  logic is_idx;
  assign is_idx       = (state == fnuv_pkg::ST_EMIT_IDX);
  assign record_kind  = is_idx ? fnuv_pkg::REC_INDEX : fnuv_pkg::REC_VERTEX;
  assign pos_x        = is_idx ? '0 : vx[rec[1:0]];
  assign pos_y        = is_idx ? '0 : vy[rec[1:0]];
  assign pos_z        = is_idx ? '0 : vz[rec[1:0]];
  assign norm_x       = is_idx ? '0 : nrm[0];
  assign norm_y       = is_idx ? '0 : nrm[1];
  assign norm_z       = is_idx ? '0 : nrm[2];
  assign vertex_index = is_idx ? next_vertex_number + 31'(idx_off) : '0;
  assign last_of_run  = is_idx && (rec == {1'b0, nidx_m1});

  logic [COORD_BITS-1:0] tu_mux, tv_mux;
  assign tu_mux = is_idx ? '0 : uv_u;
  assign tv_mux = is_idx ? '0 : uv_v;
  assign tex_u  = tu_mux;
  assign tex_v  = tv_mux;

endmodule

// ===== tb/sv/face_normal_uv_vertex_emitter_unit_tb.sv =====
// face_normal_uv_vertex_emitter_unit_tb: self-checking testbench for the face emitter
// depends on fnuv_pkg and face_normal_uv_vertex_emitter_unit
// directed vertex table and uv scale extremes, then random primitives, checked by an in-bench predictor
`timescale 1ns / 1ps

module face_normal_uv_vertex_emitter_unit_tb;

  localparam int CB = 32;
  localparam int NB = 16;
  localparam int SETTLE = 600;

  typedef struct packed {
    logic            kind;
    logic [CB-1:0]   px, py, pz;
    logic [NB-1:0]   nx, ny, nz;
    logic [CB-1:0]   tu, tv;
    logic [30:0]     idx;
    logic            last;
  } record_t;

  typedef struct {
    logic          func;
    logic [CB-1:0] x, y, z;
    bit            typed;   // expected records written out by hand
  } vtx_row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic func = 0;
  logic signed [CB-1:0] x_coord = '0, y_coord = '0, z_coord = '0;
  logic out_valid;
  logic out_stall = 0;
  logic record_kind;
  logic signed [CB-1:0] pos_x, pos_y, pos_z, tex_u, tex_v;
  logic signed [NB-1:0] norm_x, norm_y, norm_z;
  logic [30:0] vertex_index;
  logic last_of_run;

  face_normal_uv_vertex_emitter_unit #(.COORD_BITS(CB), .NORMAL_BITS(NB)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
    .out_valid(out_valid), .out_stall(out_stall), .record_kind(record_kind),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .tex_u(tex_u), .tex_v(tex_v), .vertex_index(vertex_index),
    .last_of_run(last_of_run)
  );

  always #2 clk = ~clk;

  // predictor state
  logic signed [CB-1:0] pv [4][3];
  int unsigned          pcount;
  logic                 pquad;
  logic [30:0]          pnext;
  logic [31:0]          uv_recip;

  record_t pending_records[$];
  int      mismatches;
  bit      quiet;   // no idling on either side

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [CB-1:0] uv_of(logic signed [CB-1:0] c);
    logic signed [63:0] cs;
    logic [127:0] p, q, lim;
    cs = c;
    lim = 128'd1 << (CB - 1);
    p = (cs < 0) ? 128'(-cs) : 128'(cs);
    p = p * 128'(uv_recip);
    p = p + ((cs < 0) ? 128'd32767 : 128'd32768);
    q = p >> 16;
    if (cs < 0) begin
      if (q > lim) q = lim;
      return CB'(-q);
    end
    if (q > lim - 1) q = lim - 1;
    return CB'(q);
  endfunction

  // unit face normal of vertices 0, 1, 2 of the current primitive
  task automatic face_normal(output logic [NB-1:0] nrm [3]);
    logic signed [127:0] a[3], b[3], c[3];
    logic [127:0] m[3], all;
    logic [63:0] mv[3], s2, len, q;
    int bl, sh;
    all = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = pv[2][i];
      a[i] = a[i] - pv[0][i];
      b[i] = pv[1][i];
      b[i] = b[i] - pv[0][i];
    end
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    for (int i = 0; i < 3; i++) begin
      m[i] = (c[i] < 0) ? -c[i] : c[i];
      all = all | m[i];
    end
    bl = 0;
    for (int j = 0; j < 128; j++) if (all[j]) bl = j + 1;
    sh = (bl > fnuv_pkg::MAG_BITS) ? bl - fnuv_pkg::MAG_BITS : 0;
    s2 = 0;
    for (int i = 0; i < 3; i++) begin
      mv[i] = 64'(m[i] >> sh);
      s2 = s2 + mv[i] * mv[i];
    end
    len = int_sqrt(s2);
    for (int i = 0; i < 3; i++) begin
      q = (len == 0) ? 64'd0 : ((mv[i] << (NB - 2)) + len / 2) / len;
      nrm[i] = (c[i] < 0) ? NB'(-q) : NB'(q);
    end
  endtask

  // capture one accepted vertex; queue the records of a completed primitive
  task automatic predict_vertex(logic f, logic [CB-1:0] x, y, z, bit push);
    logic [NB-1:0] nrm [3];
    record_t rec;
    int unsigned nv, ni, off;
    if (pcount == 0) pquad = f;
    pv[pcount][0] = x;
    pv[pcount][1] = y;
    pv[pcount][2] = z;
    pcount++;
    nv = pquad ? 4 : 3;
    if (pcount < nv) return;
    pcount = 0;
    face_normal(nrm);
    for (int k = 0; k < nv; k++) begin
      rec = '{fnuv_pkg::REC_VERTEX, pv[k][0], pv[k][1], pv[k][2], nrm[0], nrm[1], nrm[2],
              uv_of(pv[k][0]), uv_of(pv[k][1]), 31'd0, 1'b0};
      if (push) pending_records.push_back(rec);
    end
    ni = pquad ? 6 : 3;
    for (int k = 0; k < ni; k++) begin
      off = (pquad && k >= 3) ? ((k == 3) ? 0 : k - 2) : k;
      rec = '{fnuv_pkg::REC_INDEX, '0, '0, '0, '0, '0, '0, '0, '0, pnext + 31'(off),
              k == ni - 1};
      if (push) pending_records.push_back(rec);
    end
    pnext = pnext + 31'(nv);
  endtask

  // send one vertex item and predict on acceptance
  task automatic send_vertex(logic f, logic [CB-1:0] x, y, z, bit push = 1);
    if (!quiet && $urandom_range(99) < 27) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1;
    func <= f;
    x_coord <= x;
    y_coord <= y;
    z_coord <= z;
    do @(posedge clk); while (in_stall);
    predict_vertex(f, x, y, z, push);
    @(negedge clk);
  endtask

  // hold the sender until the block has emptied and settled
  task automatic drain;
    in_valid <= 0;
    @(negedge clk);
    while (pending_records.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_uv_recip(logic [31:0] v);
    drain();
    cfg_we <= 1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    uv_recip = v;
  endtask

  function automatic logic [CB-1:0] rand_coord();
    case ($urandom_range(3))
      0: return CB'($urandom);
      1: return CB'($signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000);
      2: return CB'($signed($urandom_range(0, 1023)) - 512) << 16;
      default: return $urandom_range(1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
    endcase
  endfunction

  // input side stall of the output channel
  always @(negedge clk) begin
    out_stall <= (!quiet && $urandom_range(99) < 27);
  end

  // compare each taken record with the oldest expected one
  always @(posedge clk) begin
    record_t e, g;
    if (!rst && out_valid && !out_stall) begin
      g = '{record_kind, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
            tex_u, tex_v, vertex_index, last_of_run};
      if (pending_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record: %p", g);
      end else begin
        e = pending_records.pop_front();
        if (e !== g) begin
          mismatches++;
          if (mismatches <= 10) $display("record mismatch\n  exp %p\n  got %p", e, g);
        end
      end
    end
  end

  // directed vertices: zero face, small faces, extremes, quad kind latch
  localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic [CB-1:0] ONE = 32'h0001_0000;
  vtx_row_t directed_rows[] = '{
    '{0, 0, 0, 0, 1}, '{1, 0, 0, 0, 1}, '{1, 0, 0, 0, 1},
    '{0, 0, 0, 0, 0}, '{0, ONE, 0, 0, 0}, '{0, 0, ONE, 0, 0},
    '{1, 0, 0, 0, 0}, '{0, ONE, 0, 0, 0}, '{0, ONE, ONE, 0, 0}, '{1, 0, ONE, 0, 0},
    '{0, CMAX, CMAX, CMAX, 0}, '{0, CMIN, CMIN, CMIN, 0}, '{0, CMIN, CMAX, 0, 0},
    '{0, CMIN, CMIN, CMIN, 0}, '{1, CMAX, CMIN, CMAX, 0}, '{0, CMAX, CMAX, CMIN, 0},
    '{1, -32'sd5, 32'sd7, -32'sd3, 0}, '{0, 32'sd9, -32'sd2, 32'sd4, 0},
    '{0, -32'sd1, -32'sd1, 32'sd8, 0}, '{1, 32'sd3, 32'sd3, 32'sd3, 0}
  };

  initial begin
    record_t zero_vtx;
    record_t zero_idx;
    mismatches = 0;
    quiet = 0;
    pcount = 0;
    pquad = 0;
    pnext = 0;
    uv_recip = 32'h0001_0000;
    repeat (11) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed part; first face is all zero, typed by hand
    zero_vtx = '{fnuv_pkg::REC_VERTEX, '0, '0, '0, '0, '0, '0, '0, '0, 31'd0, 1'b0};
    for (int i = 0; i < 3; i++) pending_records.push_back(zero_vtx);
    for (int i = 0; i < 3; i++) begin
      zero_idx = '{fnuv_pkg::REC_INDEX, '0, '0, '0, '0, '0, '0, '0, '0, 31'(i), i == 2};
      pending_records.push_back(zero_idx);
    end
    foreach (directed_rows[i])
      send_vertex(directed_rows[i].func, directed_rows[i].x, directed_rows[i].y,
                  directed_rows[i].z, !directed_rows[i].typed);

    // uv scale extremes on extreme coordinates
    write_uv_recip(32'hFFFF_FFFF);
    send_vertex(1, CMAX, CMIN, 0);
    send_vertex(0, CMIN, CMAX, ONE);
    send_vertex(0, ONE, -ONE, 0);
    send_vertex(1, 32'h0000_8000, 32'hFFFF_8000, 5);
    write_uv_recip(32'h0000_0000);
    send_vertex(0, CMAX, CMIN, 7);
    send_vertex(1, ONE, ONE, ONE);
    send_vertex(1, -ONE, ONE, 0);

    // random primitives over several uv settings, one quiet stretch
    for (int ph = 0; ph < 4; ph++) begin
      write_uv_recip(ph == 3 ? 32'h0001_0000 : $urandom);
      quiet = (ph == 2);
      for (int p = 0; p < 8; p++) begin
        int unsigned nv;
        nv = $urandom_range(1) ? 4 : 3;
        for (int k = 0; k < nv; k++)
          send_vertex(k == 0 ? (nv == 4) : $urandom_range(1),
                      rand_coord(), rand_coord(), rand_coord());
      end
    end
    quiet = 0;

    // drain and settle
    in_valid <= 0;
    while (pending_records.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
